[hw/rtl/u8vd_pkg.sv]
// Types and constants shared by the UTF-8 validating decoder.
// Holds the decoder state, the result burst descriptor and the range checks.
// Depends on nothing; used by u8vd_decode, u8vd_emit and utf8_validating_decoder.
package u8vd_pkg;

  localparam int CpWidth = 21;

  localparam logic [CpWidth-1:0] ReplCp    = 21'h00FFFD;
  localparam logic [CpWidth-1:0] MaxCp     = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrLo    = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrHi    = 21'h00DFFF;
  localparam logic [CpWidth-1:0] Min2Byte  = 21'h000080;
  localparam logic [CpWidth-1:0] Min3Byte  = 21'h000800;
  localparam logic [CpWidth-1:0] Min4Byte  = 21'h010000;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic               in_seq;
    logic [1:0]         need;
    logic [1:0]         held;
    logic [CpWidth-1:0] partial;
  } dec_state_t;

  // All results of one byte: count-1 replacements, then one last result.
  typedef struct packed {
    logic [2:0]         count;
    logic [CpWidth-1:0] last_cp;
    logic               last_bad;
    logic               fin;
  } burst_desc_t;

  // Smallest value a sequence with this many continuations may carry.
  function automatic logic [CpWidth-1:0] min_value(input logic [1:0] need);
    logic [CpWidth-1:0] v;
    case (need)
      2'd1:    v = Min2Byte;
      2'd2:    v = Min3Byte;
      2'd3:    v = Min4Byte;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/u8vd_decode.sv]
// Combinational decode of one byte against the pending sequence state.
// Produces the result burst descriptor and the next decoder state.
// Depends on u8vd_pkg.
module u8vd_decode (
  input  u8vd_pkg::dec_state_t  st,
  input  logic [7:0]            byte_in,
  input  logic                  fin,
  output u8vd_pkg::burst_desc_t desc,
  output u8vd_pkg::dec_state_t  st_next
);

  logic                            cont;
  logic                            lead_emit;
  logic [u8vd_pkg::CpWidth-1:0]    lead_cp;
  logic                            lead_bad;
  logic                            lead_open;
  logic [1:0]                      lead_need;
  logic [u8vd_pkg::CpWidth-1:0]    lead_bits;
  logic [u8vd_pkg::CpWidth-1:0]    ext_val;
  logic [1:0]                      held_inc;
  logic                            ext_bad;
  logic [2:0]                      flush_cnt;

  assign cont = (byte_in[7:6] == 2'b10);

  // Classify the byte as a lead: ASCII, opener of 2..4 bytes, or stray.
  always_comb begin
    lead_emit = 1'b0;
    lead_cp   = u8vd_pkg::ReplCp;
    lead_bad  = 1'b1;
    lead_open = 1'b0;
    lead_need = 2'd0;
    lead_bits = '0;
    if (byte_in inside {[8'h00:8'h7F]}) begin
      lead_emit = 1'b1;
      lead_cp   = {13'd0, byte_in};
      lead_bad  = 1'b0;
    end else if (byte_in inside {[8'hC0:8'hDF]}) begin
      lead_open = 1'b1;
      lead_need = 2'd1;
      lead_bits = {16'd0, byte_in[4:0]};
    end else if (byte_in inside {[8'hE0:8'hEF]}) begin
      lead_open = 1'b1;
      lead_need = 2'd2;
      lead_bits = {17'd0, byte_in[3:0]};
    end else if (byte_in inside {[8'hF0:8'hF7]}) begin
      lead_open = 1'b1;
      lead_need = 2'd3;
      lead_bits = {18'd0, byte_in[2:0]};
    end else begin
      lead_emit = 1'b1;
    end
    // A lead that is the final byte can never complete.
    if (lead_open && fin) begin
      lead_open = 1'b0;
      lead_emit = 1'b1;
    end
  end

  assign ext_val   = {st.partial[u8vd_pkg::CpWidth-7:0], byte_in[5:0]};
  assign held_inc  = st.held + 2'd1;
  assign ext_bad   = (ext_val < u8vd_pkg::min_value(st.need))
                   || ((ext_val >= u8vd_pkg::SurrLo) && (ext_val <= u8vd_pkg::SurrHi))
                   || (ext_val > u8vd_pkg::MaxCp);
  assign flush_cnt = {1'b0, st.held} + 3'd1;

  always_comb begin
    desc.fin      = fin;
    desc.count    = 3'd0;
    desc.last_cp  = u8vd_pkg::ReplCp;
    desc.last_bad = 1'b1;
    st_next       = st;
    if (st.in_seq && cont) begin
      if (held_inc >= st.need) begin
        desc.count    = 3'd1;
        desc.last_cp  = ext_bad ? u8vd_pkg::ReplCp : ext_val;
        desc.last_bad = ext_bad;
        st_next       = '0;
      end else if (fin) begin
        desc.count = {1'b0, held_inc} + 3'd1;
        st_next    = '0;
      end else begin
        st_next.held    = held_inc;
        st_next.partial = ext_val;
      end
    end else begin
      // Flush a broken sequence first, then decode the byte as a new lead.
      if (st.in_seq) begin
        desc.count = flush_cnt;
      end
      if (lead_emit) begin
        desc.count    = desc.count + 3'd1;
        desc.last_cp  = lead_cp;
        desc.last_bad = lead_bad;
      end
      st_next = '0;
      if (lead_open) begin
        st_next.in_seq  = 1'b1;
        st_next.need    = lead_need;
        st_next.partial = lead_bits;
      end
    end
    if (fin) begin
      st_next = '0;
    end
  end

endmodule

[hw/rtl/u8vd_emit.sv]
// Result register that plays out one byte's burst of results, one per cycle while m_tready is high.
// Holds a descriptor and counts down the remaining results under tready.
// Depends on u8vd_pkg.
module u8vd_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  u8vd_pkg::burst_desc_t         desc,
  output logic                          free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,  // [20:0] code_point, rest zero
  output logic                          m_tlast,  // run_last
  output logic [1:0]                    m_tuser   // [0] malformed, [1] stream_last
);

  logic                         valid;
  logic [2:0]                   remain;
  logic [u8vd_pkg::CpWidth-1:0] last_cp;
  logic                         last_bad;
  logic                         fin;
  logic                         on_last;

  assign on_last = (remain == 3'd1);
  assign free    = !valid || (on_last && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      remain <= 3'd0;
    end else if (load) begin
      valid  <= 1'b1;
      remain <= desc.count;
    end else if (valid && m_tready) begin
      if (on_last) begin
        valid <= 1'b0;
      end
      remain <= remain - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_cp  <= desc.last_cp;
      last_bad <= desc.last_bad;
      fin      <= desc.fin;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = {3'd0, on_last ? last_cp : u8vd_pkg::ReplCp};
  assign m_tlast  = on_last;
  assign m_tuser  = {on_last && fin, on_last ? last_bad : 1'b1};

endmodule

[hw/rtl/utf8_validating_decoder.sv]
// Streaming UTF-8 validating decoder, top level.
// Instantiates u8vd_decode and u8vd_emit; depends on u8vd_pkg.
//
// Usage:
//   Slave channel: one text byte per item in s_tdata[7:0]; s_tlast marks the
//   final byte of a stream and flushes any pending sequence.
//   Master channel: one code point per item in m_tdata[20:0]. m_tuser[0] is
//   set on a U+FFFD that replaces invalid input, m_tuser[1] on the last result
//   of a stream. m_tlast marks the last result caused by one input byte.
//   A byte may give no result (it opens or extends a sequence) or up to four.
// Timing:
//   An accepted byte lands in the input register. Once the result register
//   can take its results, it is decoded against the sequence state and
//   the results are loaded into it. Bytes giving zero or one result go through at
//   one per cycle while m_tready is high. A byte giving several results
//   holds the result register, one result per cycle, until all are taken;
//   only that and a low m_tready throttle the input.
// Reset (rst, synchronous): drop the byte in the input register and any
//   pending results, and leave the decoder with no open sequence.
// Stall: while m_tready is low the result register holds; bytes that give no
//   result still decode, and the input stalls only when a result must wait.
module utf8_validating_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tlast,   // run_last
  output logic [1:0]  m_tuser    // [0] malformed, [1] stream_last
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_fin;

  // Sequence state: lead seen, continuations needed and held, bits so far.
  u8vd_pkg::dec_state_t  st;
  u8vd_pkg::dec_state_t  st_next;
  u8vd_pkg::burst_desc_t desc;

  logic emit_free;
  logic advance;

  u8vd_decode u_decode (
    .st      (st),
    .byte_in (in_byte),
    .fin     (in_fin),
    .desc    (desc),
    .st_next (st_next)
  );

  // Advance the held byte when its results have somewhere to go; a byte with
  // no results needs no room in the result register.
  assign advance  = in_valid && ((desc.count == 3'd0) || emit_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_fin  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  u8vd_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && (desc.count != 3'd0)),
    .desc     (desc),
    .free     (emit_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // A pending sequence always still lacks at least one continuation.
  a_held_below_need: assert property (@(posedge clk) disable iff (rst)
    st.in_seq |-> (st.held < st.need))
    else $error("held continuations reached the needed count");

  // A final byte always leaves the decoder with no open sequence.
  a_fin_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && in_fin) |=> !st.in_seq)
    else $error("sequence left open after the final byte");

  // Every result before the last one of a byte is a replacement.
  a_early_is_repl: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser[0] && (m_tdata[20:0] == u8vd_pkg::ReplCp)))
    else $error("non-final result of a byte is not a replacement");

  // A malformed flag always carries U+FFFD.
  a_bad_is_repl: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[20:0] == u8vd_pkg::ReplCp))
    else $error("malformed result with a code point other than U+FFFD");

  // End of stream only on the last result of a byte.
  a_stream_end_on_run_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tlast)
    else $error("stream end flagged mid-burst");

endmodule
